FILE: sv/aifp_pkg.sv
// Shared types, constants and character helpers for the ASCII integer field parser.
// Used by aifp_core and ascii_integer_field_parser_unit; no dependencies.

package aifp_pkg;

    // Accumulator width and width of the value output
    localparam int VALUE_WIDTH = 64;
    localparam int OUT_WIDTH   = 64;
    localparam int CHAR_WIDTH  = 8;
    localparam int DIGIT_WIDTH = 5;

    typedef logic [CHAR_WIDTH-1:0]  char_t;
    typedef logic [VALUE_WIDTH-1:0] acc_t;
    typedef logic [DIGIT_WIDTH-1:0] digit_t;

    // Conversion phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SKIP,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    // Conversion mode as given with the start word
    typedef enum logic [1:0] {
        MODE_SDEC,
        MODE_OCT,
        MODE_HEX,
        MODE_AUTO
    } mode_t;

    // Number base; AUTO until the prefix decides it
    typedef enum logic [1:0] {
        RAD_AUTO,
        RAD_OCT,
        RAD_DEC,
        RAD_HEX
    } radix_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic                 found;
    } result_t;

    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_UA    = 8'h41;
    localparam char_t CH_UF    = 8'h46;
    localparam char_t CH_UX    = 8'h58;
    localparam char_t CH_LA    = 8'h61;
    localparam char_t CH_LF    = 8'h66;
    localparam char_t CH_LX    = 8'h78;

    localparam digit_t NO_DIGIT  = 5'h1F;
    localparam digit_t ALPHA_OFS = 5'd10;

    // Tab, line feed, vertical tab, form feed, carriage return and space
    function automatic logic is_space(input char_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Digit value of a hex character, NO_DIGIT for anything else
    function automatic digit_t hex_value(input char_t c);
        char_t  diff;
        digit_t d;
        d = NO_DIGIT;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            diff = c - CH_ZERO;
            d    = diff[DIGIT_WIDTH-1:0];
        end
        else if ((c >= CH_LA) && (c <= CH_LF))
        begin
            diff = c - CH_LA;
            d    = diff[DIGIT_WIDTH-1:0] + ALPHA_OFS;
        end
        else if ((c >= CH_UA) && (c <= CH_UF))
        begin
            diff = c - CH_UA;
            d    = diff[DIGIT_WIDTH-1:0] + ALPHA_OFS;
        end
        return d;
    endfunction

    // Numeric base of a radix code; an undecided base counts as decimal
    function automatic digit_t radix_limit(input radix_t r);
        digit_t lim;
        unique case (r)
            RAD_OCT: lim = 5'd8;
            RAD_HEX: lim = 5'd16;
            RAD_DEC: lim = 5'd10;
            RAD_AUTO: lim = 5'd10;
        endcase
        return lim;
    endfunction

endpackage

FILE: sv/aifp_core.sv
// Conversion state and per-word update of the ASCII integer field parser.
// Depends on aifp_pkg; results go to the output buffer in the top level.

module aifp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  aifp_pkg::char_t   char_in,
    input  logic              start_req,
    input  logic [1:0]        mode,
    input  logic              end_of_stream,
    output logic              res_valid,
    output aifp_pkg::result_t res
);
    import aifp_pkg::*;

    phase_t phase_reg, phase_next;
    acc_t   acc_reg, acc_next;
    radix_t radix_reg, radix_next;
    logic   signed_reg, signed_next;
    logic   neg_reg, neg_next;
    logic   seen_reg, seen_next;

    phase_t cur_phase;
    acc_t   cur_acc;
    radix_t cur_radix;
    radix_t start_radix;
    logic   cur_signed;
    logic   cur_neg;
    logic   cur_seen;

    logic   ch_space, ch_plus, ch_minus, ch_zero, ch_x;
    logic   busy, do_step, digit_ok, take_digit, finish;
    radix_t step_radix;
    digit_t digit;
    acc_t   acc_mul;
    acc_t   acc_out;

    // Base implied by the mode of a start word
    always_comb
    begin
        unique case (mode_t'(mode))
            MODE_SDEC: start_radix = RAD_DEC;
            MODE_OCT:  start_radix = RAD_OCT;
            MODE_HEX:  start_radix = RAD_HEX;
            MODE_AUTO: start_radix = RAD_AUTO;
        endcase
    end

    // A start word drops the running conversion and opens a fresh one
    always_comb
    begin
        if (start_req)
        begin
            cur_phase  = PH_SKIP;
            cur_acc    = '0;
            cur_radix  = start_radix;
            cur_signed = (mode_t'(mode) == MODE_SDEC);
            cur_neg    = 1'b0;
            cur_seen   = 1'b0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_acc    = acc_reg;
            cur_radix  = radix_reg;
            cur_signed = signed_reg;
            cur_neg    = neg_reg;
            cur_seen   = seen_reg;
        end
    end

    // Classify the character
    assign ch_space = is_space(char_in);
    assign ch_plus  = (char_in == CH_PLUS);
    assign ch_minus = (char_in == CH_MINUS);
    assign ch_zero  = (char_in == CH_ZERO);
    assign ch_x     = (char_in == CH_LX) || (char_in == CH_UX);
    assign digit    = hex_value(char_in);

    // Base used for a digit: after a lone leading zero an open base means octal
    always_comb
    begin
        step_radix = cur_radix;
        if (cur_radix == RAD_AUTO)
        begin
            step_radix = (cur_phase == PH_ZERO) ? RAD_OCT : RAD_DEC;
        end
    end

    assign digit_ok = (digit < radix_limit(step_radix));
    assign busy     = fire && (cur_phase != PH_IDLE) && !end_of_stream;

    // Decide whether this character goes through the digit rule
    always_comb
    begin
        unique case (cur_phase)
            PH_SKIP:
                do_step = !ch_space
                          && !(cur_signed && (ch_plus || ch_minus))
                          && !(!cur_signed && ch_zero);
            PH_ZERO:   do_step = !ch_x;
            PH_DIGITS: do_step = 1'b1;
            PH_IDLE:   do_step = 1'b0;
        endcase
    end

    assign take_digit = busy && do_step && digit_ok;
    assign finish     = fire && (cur_phase != PH_IDLE)
                        && (end_of_stream || (do_step && !digit_ok));

    // Phase update
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            phase_next = cur_phase;
            if (cur_phase != PH_IDLE)
            begin
                if (end_of_stream)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    unique case (cur_phase)
                        PH_SKIP:
                        begin
                            priority if (ch_space)
                                phase_next = PH_SKIP;
                            else if (cur_signed && (ch_plus || ch_minus))
                                phase_next = PH_DIGITS;
                            else if (!cur_signed && ch_zero)
                                phase_next = PH_ZERO;
                            else
                                phase_next = digit_ok ? PH_DIGITS : PH_IDLE;
                        end
                        PH_ZERO:
                        begin
                            if (ch_x)
                                phase_next = PH_DIGITS;
                            else
                                phase_next = digit_ok ? PH_DIGITS : PH_IDLE;
                        end
                        PH_DIGITS: phase_next = digit_ok ? PH_DIGITS : PH_IDLE;
                        PH_IDLE:   phase_next = PH_IDLE;
                    endcase
                end
            end
        end
    end

    // Multiply by the base with shifts and adds
    always_comb
    begin
        unique case (step_radix)
            RAD_OCT:  acc_mul = cur_acc << 3;
            RAD_HEX:  acc_mul = cur_acc << 4;
            RAD_DEC:  acc_mul = (cur_acc << 3) + (cur_acc << 1);
            RAD_AUTO: acc_mul = (cur_acc << 3) + (cur_acc << 1);
        endcase
    end

    // Datapath update
    always_comb
    begin
        acc_next    = acc_reg;
        radix_next  = radix_reg;
        signed_next = signed_reg;
        neg_next    = neg_reg;
        seen_next   = seen_reg;
        if (fire)
        begin
            acc_next    = take_digit ? (acc_mul + acc_t'(digit)) : cur_acc;
            signed_next = cur_signed;
            neg_next    = cur_neg
                          || (busy && (cur_phase == PH_SKIP) && cur_signed && ch_minus);
            seen_next   = cur_seen || take_digit
                          || (busy && (cur_phase == PH_SKIP) && !cur_signed && ch_zero);
            radix_next  = cur_radix;
            if (busy && (cur_radix == RAD_AUTO))
            begin
                if ((cur_phase == PH_SKIP) && !ch_space && !ch_zero)
                    radix_next = RAD_DEC;
                else if (cur_phase == PH_ZERO)
                    radix_next = ch_x ? RAD_HEX : RAD_OCT;
            end
        end
    end

    // Result word: negate after a minus sign in signed mode
    assign acc_out   = (cur_signed && cur_neg) ? ((~cur_acc) + acc_t'(1)) : cur_acc;
    assign res_valid = finish;
    assign res.value = OUT_WIDTH'(acc_out);
    assign res.found = cur_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            acc_reg    <= '0;
            radix_reg  <= RAD_AUTO;
            signed_reg <= 1'b0;
            neg_reg    <= 1'b0;
            seen_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            radix_reg  <= radix_next;
            signed_reg <= signed_next;
            neg_reg    <= neg_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

FILE: sv/ascii_integer_field_parser_unit.sv
// Top level of the ASCII integer field parser: input handshake and output buffer.
// Depends on aifp_pkg and aifp_core.
//
// Usage:
//   The input channel carries one character word per cycle (char_in, start_req,
//   mode, end_of_stream) under in_valid / in_stall. A word with start_req set
//   opens a field in the given mode; leading white space, one sign (signed
//   decimal only) and a 0 / 0x prefix are handled, then digits accumulate.
//   The word that ends a field (a non-digit or end_of_stream) is consumed and
//   yields one result word (value, found) on out_valid / out_stall.
//   Throughput: one input word per cycle while in_stall is low; each word is decoded and folded into
//   the accumulator in the cycle it is accepted (shift-add multiply by 8, 10, 16).
//   The result is registered in the output register, or in skid behind a stall.
//   Stall: a two-entry output buffer (output register plus skid register) lets
//   input continue while one result waits; in_stall rises only when both hold
//   a result, and out_* hold steady while out_stall is high.
//   Reset (rst_n low, asynchronous) empties the buffer and idles the parser;
//   words without start_req are ignored while idle.

module ascii_integer_field_parser_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [aifp_pkg::CHAR_WIDTH-1:0]    char_in,
    input  logic                               start_req,
    input  logic [1:0]                         mode,
    input  logic                               end_of_stream,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [aifp_pkg::OUT_WIDTH-1:0]     value,
    output logic                               found
);
    import aifp_pkg::*;

    logic    fire;
    logic    out_take;
    logic    res_valid;
    result_t res;

    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    assign in_stall = skid_valid_reg;
    assign fire     = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    aifp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .char_in       (char_in),
        .start_req     (start_req),
        .mode          (mode),
        .end_of_stream (end_of_stream),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Advance the output buffer: drain to the output register, park in skid on stall
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (res_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold result payload; no reset needed
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = out_reg.value;
    assign found     = out_reg.found;

endmodule

FILE: tb/sv/aifp_result_check.sv
// Result checker for the ASCII integer field parser: follows every accepted character
// word, predicts the value and found flag of each field and compares the result words.
// Depends on aifp_pkg.

module aifp_result_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  aifp_pkg::char_t                char_in,
    input  logic                           start_req,
    input  logic [1:0]                     mode,
    input  logic                           end_of_stream,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [aifp_pkg::OUT_WIDTH-1:0] value,
    input  logic                           found,
    output int                             mismatches,
    output int                             awaiting
);
    import aifp_pkg::*;

    localparam int unsigned BASE_OPEN   = 0;
    localparam int unsigned BASE_OCT    = 8;
    localparam int unsigned BASE_DEC    = 10;
    localparam int unsigned BASE_HEX    = 16;
    localparam int unsigned NOT_A_DIGIT = 99;

    // Field state of the prediction
    phase_t      fld_phase;
    acc_t        fld_acc;
    int unsigned fld_base;
    logic        fld_signed;
    logic        fld_neg;
    logic        fld_seen;
    int          fail_total;
    result_t     pending_fields[$];

    function automatic logic blank_char(input char_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic int unsigned char_digit(input char_t c);
        if ((c >= CH_ZERO) && (c <= CH_NINE))
            return 32'(c - CH_ZERO);
        if ((c >= CH_LA) && (c <= CH_LF))
            return c - CH_LA + 10;
        if ((c >= CH_UA) && (c <= CH_UF))
            return c - CH_UA + 10;
        return NOT_A_DIGIT;
    endfunction

    // Close the field: apply the sign and queue the expected result word
    task automatic close_field();
        result_t r;
        acc_t    v;
        v = fld_acc;
        if (fld_signed && fld_neg)
            v = -v;
        r.value = OUT_WIDTH'(v);
        r.found = fld_seen;
        pending_fields.push_back(r);
        fld_phase = PH_IDLE;
    endtask

    // Fold one digit into the accumulator, or end the field on a non-digit
    task automatic take_digit(input char_t c);
        int unsigned r;
        int unsigned d;
        r = (fld_base == BASE_OPEN) ? BASE_DEC : fld_base;
        d = char_digit(c);
        if (d >= r)
            close_field();
        else
        begin
            fld_acc   = fld_acc * acc_t'(r) + acc_t'(d);
            fld_seen  = 1'b1;
            fld_phase = PH_DIGITS;
        end
    endtask

    // Advance the prediction by one accepted character word
    task automatic fold_word(input char_t c, input logic st, input mode_t md, input logic eos);
        if (st)
        begin
            fld_phase  = PH_SKIP;
            fld_acc    = '0;
            fld_neg    = 1'b0;
            fld_seen   = 1'b0;
            fld_signed = (md == MODE_SDEC);
            case (md)
                MODE_SDEC: fld_base = BASE_DEC;
                MODE_OCT:  fld_base = BASE_OCT;
                MODE_HEX:  fld_base = BASE_HEX;
                default:   fld_base = BASE_OPEN;
            endcase
        end
        if (fld_phase == PH_IDLE)
            return;
        if (eos)
        begin
            close_field();
            return;
        end
        case (fld_phase)
            PH_SKIP:
            begin
                if (!blank_char(c))
                begin
                    if (fld_signed)
                    begin
                        if (c == CH_PLUS)
                            fld_phase = PH_DIGITS;
                        else if (c == CH_MINUS)
                        begin
                            fld_neg   = 1'b1;
                            fld_phase = PH_DIGITS;
                        end
                        else
                            take_digit(c);
                    end
                    else if (c == CH_ZERO)
                    begin
                        fld_seen  = 1'b1;
                        fld_phase = PH_ZERO;
                    end
                    else
                    begin
                        if (fld_base == BASE_OPEN)
                            fld_base = BASE_DEC;
                        take_digit(c);
                    end
                end
            end
            PH_ZERO:
            begin
                if ((c == CH_LX) || (c == CH_UX))
                begin
                    if (fld_base == BASE_OPEN)
                        fld_base = BASE_HEX;
                    fld_phase = PH_DIGITS;
                end
                else
                begin
                    if (fld_base == BASE_OPEN)
                        fld_base = BASE_OCT;
                    take_digit(c);
                end
            end
            default:
                take_digit(c);
        endcase
    endtask

    // Predict on accepted input words, compare on accepted result words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fld_phase  = PH_IDLE;
            fld_acc    = '0;
            fld_base   = BASE_OPEN;
            fld_signed = 1'b0;
            fld_neg    = 1'b0;
            fld_seen   = 1'b0;
            fail_total = 0;
            pending_fields.delete();
            mismatches <= 0;
            awaiting   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                fold_word(char_in, start_req, mode_t'(mode), end_of_stream);
            if (out_valid && !out_stall)
            begin
                if (pending_fields.size() == 0)
                begin
                    $error("unexpected result word: value %h found %b", value, found);
                    fail_total++;
                end
                else
                begin
                    if (value !== pending_fields[0].value)
                    begin
                        $error("value: expected %h, actual %h", pending_fields[0].value, value);
                        fail_total++;
                    end
                    if (found !== pending_fields[0].found)
                    begin
                        $error("found: expected %b, actual %b", pending_fields[0].found, found);
                        fail_total++;
                    end
                    void'(pending_fields.pop_front());
                end
            end
            mismatches <= fail_total;
            awaiting   <= pending_fields.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the ASCII integer field parser test: clock, reset, character stimulus,
// receiver stalls, watchdog and verdict. Depends on aifp_pkg, aifp_result_check
// and ascii_integer_field_parser_unit.

module testbench;
    import aifp_pkg::*;

    localparam int unsigned WORD_TARGET  = 1050;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 150;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    char_t                 char_in;
    logic                  start_req;
    logic [1:0]            mode;
    logic                  end_of_stream;
    logic                  out_valid;
    logic                  out_stall;
    logic [OUT_WIDTH-1:0]  value;
    logic                  found;
    int                    mismatches;
    int                    awaiting;
    int unsigned           words_sent;
    int unsigned           burst_left;
    int unsigned           idle_cycles = 0;

    always #5 clk = ~clk;

    ascii_integer_field_parser_unit DUT (.*);

    aifp_result_check result_check (.*);

    // Offer one character word; sometimes idle between bursts and hold until accepted
    task automatic offer_word(input char_t c, input logic st, input logic [1:0] md,
                              input logic eos);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid      <= 1'b1;
        char_in       <= c;
        start_req     <= st;
        mode          <= md;
        end_of_stream <= eos;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    function automatic char_t blank();
        int unsigned r;
        r = $urandom_range(CH_TAB, CH_CR + 1);
        return (r > CH_CR) ? CH_SPACE : char_t'(r);
    endfunction

    function automatic char_t digit_char(input int unsigned v);
        if (v < 10)
            return CH_ZERO + char_t'(v);
        if ($urandom_range(0, 1) == 1)
            return CH_UA + char_t'(v - 10);
        return CH_LA + char_t'(v - 10);
    endfunction

    // Well-formed field: blanks, sign or prefix, digits of the base, terminator
    task automatic send_field();
        char_t       text[$];
        mode_t       md;
        int unsigned base;
        int unsigned pick;
        int unsigned ndig;
        md   = mode_t'($urandom_range(0, 3));
        base = (md == MODE_OCT) ? 8 : (md == MODE_HEX) ? 16 : 10;
        repeat ($urandom_range(0, 2)) text.push_back(blank());
        pick = $urandom_range(0, 3);
        if (md == MODE_SDEC)
        begin
            if (pick == 1)
                text.push_back(CH_PLUS);
            else if (pick == 2)
                text.push_back(CH_MINUS);
        end
        else if (pick == 1)
        begin
            text.push_back(CH_ZERO);
            if (md == MODE_AUTO)
                base = 8;
        end
        else if (pick >= 2)
        begin
            text.push_back(CH_ZERO);
            text.push_back(($urandom_range(0, 1) == 1) ? CH_UX : CH_LX);
            if (md == MODE_AUTO)
                base = 16;
        end
        ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 26) : $urandom_range(1, 8);
        repeat (ndig) text.push_back(digit_char($urandom_range(0, base - 1)));
        foreach (text[i])
            offer_word(text[i], i == 0, (i == 0) ? 2'(md) : 2'($urandom_range(0, 3)), 1'b0);
        offer_word(char_t'($urandom_range(0, 255)), 1'b0, 2'($urandom_range(0, 3)),
                   $urandom_range(0, 2) == 0);
    endtask

    // Random words: stray starts, ends of stream and any character
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            offer_word(char_t'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                       2'($urandom_range(0, 3)), $urandom_range(0, 6) == 0);
    endtask

    // Receiver: stall style is redrawn from four patterns, with two long hold-offs
    initial
    begin
        int unsigned cyc;
        int unsigned style;
        int unsigned hold;
        cyc       = 0;
        style     = 0;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
                style = $urandom_range(0, 3);
            if ((cyc == 500) || (cyc == 1200))
                hold = HOLD_CYCLES;
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        char_in       = '0;
        start_req     = 1'b0;
        mode          = MODE_SDEC;
        end_of_stream = 1'b0;
        words_sent    = 0;
        burst_left    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle without start: ignored
        offer_word("Q", 1'b0, MODE_SDEC, 1'b0);
        // End of stream before any digit
        offer_word(CH_ZERO, 1'b1, MODE_SDEC, 1'b1);
        // Blank, minus, digit, end of stream; mode on later words is ignored
        offer_word(CH_SPACE, 1'b1, MODE_SDEC, 1'b0);
        offer_word(CH_MINUS, 1'b0, MODE_OCT, 1'b0);
        offer_word(CH_NINE, 1'b0, MODE_AUTO, 1'b0);
        offer_word(8'h00, 1'b0, MODE_HEX, 1'b1);
        // Sign without digits
        offer_word(CH_PLUS, 1'b1, MODE_SDEC, 1'b0);
        offer_word(";", 1'b0, MODE_SDEC, 1'b0);
        // Hex mode with 0x prefix, ended by a character above 127
        offer_word(CH_ZERO, 1'b1, MODE_HEX, 1'b0);
        offer_word(CH_LX, 1'b0, MODE_HEX, 1'b0);
        offer_word(CH_LF, 1'b0, MODE_HEX, 1'b0);
        offer_word(CH_UF, 1'b0, MODE_HEX, 1'b0);
        offer_word(8'hFF, 1'b0, MODE_HEX, 1'b0);
        // Auto base: 0X followed by a non-digit
        offer_word(CH_ZERO, 1'b1, MODE_AUTO, 1'b0);
        offer_word(CH_UX, 1'b0, MODE_AUTO, 1'b0);
        offer_word("g", 1'b0, MODE_AUTO, 1'b0);
        // Auto base octal, ended by an 8
        offer_word(CH_ZERO, 1'b1, MODE_AUTO, 1'b0);
        offer_word("7", 1'b0, MODE_AUTO, 1'b0);
        offer_word("8", 1'b0, MODE_AUTO, 1'b0);
        // Octal mode: a 9 ends the field at once
        offer_word(CH_NINE, 1'b1, MODE_OCT, 1'b0);
        // Start while busy drops the running field
        offer_word("5", 1'b1, MODE_AUTO, 1'b0);
        offer_word("3", 1'b1, MODE_SDEC, 1'b0);
        offer_word(8'hFF, 1'b0, MODE_SDEC, 1'b1);

        // Random part: mostly well-formed fields, some noise
        while (words_sent < WORD_TARGET)
        begin
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_field();
        end
        in_valid <= 1'b0;

        // Drain the remaining results
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if ((mismatches == 0) && (awaiting == 0))
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
